// ----- src/pldm_pkg.sv -----
// Shared widths, calibration tables and stream types for the power-to-DAC mapper.
package pldm_pkg;

   // Field widths
   localparam int SETTING_W = 10;
   localparam int CODE_W    = 12;
   localparam int SLOPE_W   = 5;
   localparam int PROD_W    = SETTING_W + SLOPE_W;
   localparam int SUM_W     = PROD_W + 1;

   // Stream data widths, fields padded to whole bytes
   localparam int REQ_DATA_W = ((SETTING_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CODE_W + 7) / 8) * 8;

   // Calibration table size
   localparam int BREAKPOINTS = 15;
   localparam int SEGMENTS    = BREAKPOINTS - 1;

   localparam logic [CODE_W-1:0] DAC_MAX = CODE_W'(4095);

   typedef logic [SETTING_W-1:0] setting_type;
   typedef logic [CODE_W-1:0]    code_type;
   typedef logic [SLOPE_W-1:0]   slope_type;

   // Breakpoint settings in per-mille, falling from the top
   localparam setting_type BP_SETTING [BREAKPOINTS] = '{
      10'd1000, 10'd950, 10'd900, 10'd850, 10'd800, 10'd700, 10'd600, 10'd500,
      10'd400,  10'd300, 10'd200, 10'd150, 10'd100, 10'd50,  10'd0
   };

   // DAC code at each breakpoint
   localparam code_type BP_CODE [BREAKPOINTS] = '{
      12'd4000, 12'd3600, 12'd3400, 12'd3300, 12'd3200, 12'd2800, 12'd2600, 12'd2400,
      12'd2200, 12'd2000, 12'd1800, 12'd1650, 12'd1500, 12'd1300, 12'd0
   };

   // Whole-number slope of each segment, DAC steps per per-mille
   localparam slope_type SEG_SLOPE [SEGMENTS] = '{
      5'd8, 5'd4, 5'd2, 5'd2, 5'd4, 5'd2, 5'd2,
      5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd4, 5'd26
   };

endpackage

// ----- src/piecewise_linear_dac_mapper.sv -----
// Power setting to DAC code mapper: segment search, linear interpolation, clamp.
//
//   channel   ports     direction   payload
//   request   req_*     in          tdata[9:0]  power_setting
//   response  rsp_*     out         tdata[11:0] dac_code
//
// Response valid rises once the request item has passed the input stage and the
// output register. One item per cycle is sustained while the response side is ready:
// each stage takes a new item in the same cycle it hands its own on.
// Reset is synchronous and clears both valid flags.
// A stalled response holds its register and the input stage fills behind it;
// the request side stalls only when both stages are occupied.
module piecewise_linear_dac_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pldm_pkg::REQ_DATA_W-1:0] req_tdata,  // [9:0] power_setting, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pldm_pkg::RSP_DATA_W-1:0] rsp_tdata   // [11:0] dac_code, rest zero
);

   logic                  in_valid_ff, in_valid_in;
   pldm_pkg::setting_type in_setting_ff;
   logic                  out_valid_ff, out_valid_in;
   pldm_pkg::code_type    out_code_ff, out_code_in;

   logic                  out_free;
   logic                  in_advance;
   logic                  req_xfer;

   logic [pldm_pkg::SEGMENTS-1:0] seg_hit;
   logic                          any_hit;
   pldm_pkg::setting_type         sel_x_low;
   pldm_pkg::code_type            sel_y_low;
   pldm_pkg::slope_type           sel_slope;
   pldm_pkg::setting_type         offset;
   logic [pldm_pkg::PROD_W-1:0]   product;
   logic [pldm_pkg::SUM_W-1:0]    sum;

   // Handshake: output register frees on transfer, input stage moves when it frees
   assign out_free    = !out_valid_ff || rsp_tready;
   assign in_advance  = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign req_xfer    = req_tvalid && req_tready;
   assign in_valid_in = req_xfer || (in_valid_ff && !out_free);
   assign out_valid_in = in_advance || (out_valid_ff && !rsp_tready);

   // Closed-interval compare against every segment in parallel
   always_comb begin
      for (int i = 0; i < pldm_pkg::SEGMENTS; i++) begin
         seg_hit[i] = (in_setting_ff >= pldm_pkg::BP_SETTING[i+1]) &&
                      (in_setting_ff <= pldm_pkg::BP_SETTING[i]);
      end
   end

   // Priority select: the highest segment that holds the setting wins
   always_comb begin
      sel_x_low = '0;
      sel_y_low = '0;
      sel_slope = '0;
      for (int i = pldm_pkg::SEGMENTS - 1; i >= 0; i--) begin
         if (seg_hit[i]) begin
            sel_x_low = pldm_pkg::BP_SETTING[i+1];
            sel_y_low = pldm_pkg::BP_CODE[i+1];
            sel_slope = pldm_pkg::SEG_SLOPE[i];
         end
      end
   end

   assign any_hit = |seg_hit;

   // Interpolate and clamp; no segment gives zero
   always_comb begin
      offset  = in_setting_ff - sel_x_low;
      product = pldm_pkg::PROD_W'(sel_slope) * pldm_pkg::PROD_W'(offset);
      sum     = pldm_pkg::SUM_W'(sel_y_low) + pldm_pkg::SUM_W'(product);
      if (!any_hit) begin
         out_code_in = '0;
      end else if (sum > pldm_pkg::SUM_W'(pldm_pkg::DAC_MAX)) begin
         out_code_in = pldm_pkg::DAC_MAX;
      end else begin
         out_code_in = sum[pldm_pkg::CODE_W-1:0];
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_setting_ff <= req_tdata[pldm_pkg::SETTING_W-1:0];
      end
      if (in_advance) begin
         out_code_ff <= out_code_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pldm_pkg::RSP_DATA_W'(out_code_ff);

   // A request transfer always lands in the input stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("request transfer did not fill input stage");

   // A held input item keeps its setting until it moves on
   a_in_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_setting_ff)))
      else $error("stalled input item lost or changed");

   // An item leaving the input stage shows up as a response
   a_out_fills: assert property (@(posedge clock) disable iff (reset)
      in_advance |=> rsp_tvalid)
      else $error("advanced item missing at response");

   // Settings above full scale map to zero
   a_over_range: assert property (@(posedge clock) disable iff (reset)
      (in_advance && (in_setting_ff > pldm_pkg::BP_SETTING[0])) |=> (out_code_ff == '0))
      else $error("out-of-range setting gave nonzero code");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the power-setting to DAC-code mapper.
module tb_top;

   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int PHASES        = 3;
   localparam int HOLD_CYCLES   = 200;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PRINT_LIMIT   = 40;
   localparam int NUM_DIRECTED  = 25;
   localparam int CAL_POINTS    = 15;
   localparam int CODE_CEILING  = 4095;
   localparam int SETTING_TOP   = 1000;
   localparam int SETTING_FIELD = 1023;
   localparam int PAD_W         = pldm_pkg::REQ_DATA_W - pldm_pkg::SETTING_W;

   // Idle percentages per phase: sender-heavy receiver idling, then swapped, then none
   localparam int SENDER_IDLE   [PHASES] = '{16, 50, 0};
   localparam int RECEIVER_IDLE [PHASES] = '{50, 16, 0};

   // Calibration curve, settings falling from the top of the range
   localparam int CAL_SETTING [CAL_POINTS] = '{
      1000, 950, 900, 850, 800, 700, 600, 500, 400, 300, 200, 150, 100, 50, 0
   };
   localparam int CAL_CODE [CAL_POINTS] = '{
      4000, 3600, 3400, 3300, 3200, 2800, 2600, 2400, 2200, 2000, 1800, 1650, 1500, 1300, 0
   };

   // One outstanding conversion: the setting sent and the code it should give
   typedef struct packed {
      pldm_pkg::setting_type setting;
      pldm_pkg::code_type    code;
   } conversion_type;

   // Directed row: typed marks a code read straight off the calibration curve
   typedef struct packed {
      pldm_pkg::setting_type setting;
      logic                  typed;
      pldm_pkg::code_type    code;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{10'd0,    1'b1, 12'd0},     // bottom of range
      '{10'd1000, 1'b1, 12'd4000},  // top of range
      '{10'd1001, 1'b1, 12'd0},     // just above range
      '{10'd1023, 1'b1, 12'd0},     // all ones, above range
      '{10'd950,  1'b1, 12'd3600},  // shared breakpoints from here down
      '{10'd900,  1'b1, 12'd3400},
      '{10'd850,  1'b1, 12'd3300},
      '{10'd800,  1'b1, 12'd3200},
      '{10'd700,  1'b1, 12'd2800},
      '{10'd600,  1'b1, 12'd2600},
      '{10'd500,  1'b1, 12'd2400},
      '{10'd400,  1'b1, 12'd2200},
      '{10'd300,  1'b1, 12'd2000},
      '{10'd200,  1'b1, 12'd1800},
      '{10'd150,  1'b1, 12'd1650},
      '{10'd100,  1'b1, 12'd1500},
      '{10'd50,   1'b1, 12'd1300},
      '{10'd1,    1'b0, 12'd0},     // steepest segment
      '{10'd49,   1'b0, 12'd0},
      '{10'd51,   1'b0, 12'd0},
      '{10'd999,  1'b0, 12'd0},
      '{10'd951,  1'b0, 12'd0},
      '{10'd511,  1'b0, 12'd0},
      '{10'd512,  1'b0, 12'd0},
      '{10'd767,  1'b0, 12'd0}
   };

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pldm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // [9:0] power_setting
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pldm_pkg::RSP_DATA_W-1:0] rsp_tdata;        // [11:0] dac_code

   conversion_type pending_conversions [$];
   int             mismatch_count = 0;
   int             req_idle_pct   = 0;
   int             rsp_idle_pct   = 0;
   bit             hold_go        = 1'b0;
   bit             hold_done      = 1'b0;
   int             hold_count     = 0;
   int             quiet_cycles   = 0;
   conversion_type oldest;

   always #1 clock = ~clock;

   piecewise_linear_dac_mapper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Segment search from the top, linear interpolation, clamp to the code range
   function automatic pldm_pkg::code_type interpolate_dac_code(
         input pldm_pkg::setting_type power);
      int x;
      int y;
      int dx;
      int slope;
      int seg;
      x = int'(power);
      y = 0;
      for (seg = 0; seg < CAL_POINTS - 1; seg++) begin
         if (x >= CAL_SETTING[seg+1] && x <= CAL_SETTING[seg]) begin
            dx    = CAL_SETTING[seg] - CAL_SETTING[seg+1];
            slope = (dx != 0) ? (CAL_CODE[seg] - CAL_CODE[seg+1]) / dx : 0;
            y     = CAL_CODE[seg+1] + slope * (x - CAL_SETTING[seg+1]);
            break;
         end
      end
      if (y < 0) y = 0;
      if (y > CODE_CEILING) y = CODE_CEILING;
      return pldm_pkg::code_type'(y);
   endfunction

   // Mostly in-range settings, with breakpoint neighbors and out-of-range ones mixed in
   function automatic pldm_pkg::setting_type pick_setting();
      int roll;
      int x;
      roll = $urandom_range(99);
      if (roll < 70) begin
         x = $urandom_range(SETTING_TOP);
      end else if (roll < 80) begin
         x = CAL_SETTING[$urandom_range(CAL_POINTS - 1)] + $urandom_range(2) - 1;
         if (x < 0) x = 0;
      end else if (roll < 90) begin
         x = $urandom_range(SETTING_FIELD, SETTING_TOP + 1);
      end else begin
         x = $urandom_range(SETTING_FIELD);
      end
      return pldm_pkg::setting_type'(x);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Offer one setting, with random idle cycles ahead of it, and log it on transfer
   task automatic send_setting(input pldm_pkg::setting_type power,
                               input pldm_pkg::code_type code);
      conversion_type item;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, power};
      do @(posedge clock); while (!req_tready);
      item.setting = power;
      item.code    = code;
      pending_conversions.push_back(item);
   endtask

   // Receiver: random backpressure, plus one long hold-off to fill the pipe
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Response checker against the oldest pending conversion
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_conversions.size() == 0) begin
            report_mismatch($sformatf("unexpected response, dac_code %0d",
                                      rsp_tdata[pldm_pkg::CODE_W-1:0]));
         end else begin
            oldest = pending_conversions.pop_front();
            if (rsp_tdata[pldm_pkg::CODE_W-1:0] !== oldest.code)
               report_mismatch($sformatf("setting %0d: dac_code %0d, expected %0d",
                                         oldest.setting,
                                         rsp_tdata[pldm_pkg::CODE_W-1:0], oldest.code));
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed table, then three random phases
   initial begin
      int row;
      int phase;
      int n;
      pldm_pkg::setting_type power;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = SENDER_IDLE[0];
      rsp_idle_pct = RECEIVER_IDLE[0];
      for (row = 0; row < NUM_DIRECTED; row++) begin
         power = DIRECTED_ROWS[row].setting;
         send_setting(power, DIRECTED_ROWS[row].typed ? DIRECTED_ROWS[row].code
                                                      : interpolate_dac_code(power));
      end

      for (phase = 0; phase < PHASES; phase++) begin
         req_idle_pct = SENDER_IDLE[phase];
         rsp_idle_pct = RECEIVER_IDLE[phase];
         // long receiver hold-off while the sender keeps offering
         if (phase == PHASES - 1) hold_go = 1'b1;
         for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            power = pick_setting();
            send_setting(power, interpolate_dac_code(power));
         end
      end
      req_tvalid <= 1'b0;

      while (pending_conversions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/pldm_pkg.sv
src/piecewise_linear_dac_mapper.sv
verif/tb_top.sv
